// ----- rtl/ttcs_pkg.sv -----
// ttcs_pkg: shared types, constants and decode helpers for the text terminal core
// used by every file of the block but ttcs_ram, no dependencies
package ttcs_pkg;

    // screen geometry
    localparam int COLUMNS = 64;
    localparam int ROWS    = 16;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int ADDR_W  = $clog2(CELLS);

    // beat field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 10;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CHAR_W-1:0] t_char;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // character codes
    localparam t_char CODE_LF       = 8'h0a;
    localparam t_char CODE_FF       = 8'h0c;
    localparam t_char CODE_CR       = 8'h0d;
    localparam t_char CODE_LEFT     = 8'h0f;
    localparam t_char CODE_PRINT_LO = 8'h20;
    localparam t_char CODE_PRINT_HI = 8'h7e;
    localparam t_char CODE_ERASE    = 8'h7f;
    localparam t_char BLANK         = 8'h20;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LF,
        OP_CR,
        OP_FF,
        OP_LEFT,
        OP_ERASE,
        OP_PRINT
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_BLANK,
        S_FILL
    } t_state;

    // what the ram sweep does this cycle
    typedef enum logic [1:0] {
        SW_NONE,
        SW_MOVE,
        SW_BLANK,
        SW_ZERO
    } t_sweep;

    typedef struct packed {
        logic   take;
        t_sweep sweep;
        logic   cnt_clr;
        logic   cnt_inc;
        logic   ld_out;
        logic   out_from_ram;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic last_row;
        logic at_end;
        logic move_end;
        logic cnt_end;
    } t_status;

    // classify a put code
    function automatic t_op decode_op(input t_char code);
        t_op op;
        op = OP_NONE;
        case (code)
            CODE_LF:    op = OP_LF;
            CODE_CR:    op = OP_CR;
            CODE_FF:    op = OP_FF;
            CODE_LEFT:  op = OP_LEFT;
            CODE_ERASE: op = OP_ERASE;
            default: begin
                if (code inside {[CODE_PRINT_LO:CODE_PRINT_HI]}) begin
                    op = OP_PRINT;
                end
            end
        endcase
        return op;
    endfunction

    // row/column to linear cell index
    function automatic t_addr cell_index(input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col);
        return t_addr'(row) * t_addr'(COLUMNS) + t_addr'(col);
    endfunction

endpackage

// ----- rtl/ttcs_if.sv -----
// ttcs_in_if / ttcs_out_if: valid/ready channels of the text terminal core
// depends on ttcs_pkg for field widths
interface ttcs_in_if;
    logic                         valid;
    logic                         ready;
    logic [ttcs_pkg::CMD_W-1:0]   command;
    logic [ttcs_pkg::CHAR_W-1:0]  char_code;
    logic [ttcs_pkg::POS_W-1:0]   read_address;

    modport source (output valid, output command, output char_code,
                    output read_address, input ready);
    modport sink   (input valid, input command, input char_code,
                    input read_address, output ready);
endinterface

interface ttcs_out_if;
    logic                         valid;
    logic                         ready;
    logic [ttcs_pkg::POS_W-1:0]   cursor_position;
    logic [ttcs_pkg::CHAR_W-1:0]  cell_data;

    modport source (output valid, output cursor_position, output cell_data,
                    input ready);
    modport sink   (input valid, input cursor_position, input cell_data,
                    output ready);
endinterface

// ----- rtl/ttcs_ram.sv -----
// ttcs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ttcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/ttcs_ctrl.sv -----
// ttcs_ctrl: controller state machine of the text terminal core
// depends on ttcs_pkg; drives ttcs_datapath through t_cmd and reads t_status
module ttcs_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [ttcs_pkg::CMD_W-1:0]   i_command,
    input  logic [ttcs_pkg::CHAR_W-1:0]  i_char_code,
    input  ttcs_pkg::t_status            i_status,
    output logic                         o_in_ready,
    output ttcs_pkg::t_cmd               o_cmd
);
    import ttcs_pkg::*;

    t_state r_state;
    t_state n_state;
    t_op    op;
    logic   accept;
    logic   long_op;

    assign op     = decode_op(i_char_code);
    assign accept = i_in_valid && o_in_ready;

    // put codes that need a sweep over the screen
    assign long_op = (i_command == CMD_PUT) &&
                     ((op == OP_FF) ||
                      (op == OP_LF && i_status.last_row) ||
                      (op == OP_PRINT && i_status.at_end));

    // state register, reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.cnt_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_READ) begin
                        n_state = S_READ;
                    end else if (long_op) begin
                        n_state = (op == OP_FF) ? S_FILL : S_SCROLL;
                    end
                end
            end
            S_READ:   n_state = S_IDLE;
            S_SCROLL: begin
                if (i_status.move_end) n_state = S_BLANK;
            end
            S_BLANK, S_FILL: begin
                if (i_status.cnt_end) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready         = 1'b0;
        o_cmd.take         = 1'b0;
        o_cmd.sweep        = SW_NONE;
        o_cmd.cnt_clr      = 1'b0;
        o_cmd.cnt_inc      = 1'b0;
        o_cmd.ld_out       = 1'b0;
        o_cmd.out_from_ram = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep   = SW_ZERO;
                o_cmd.cnt_inc = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = i_status.out_free;
                if (accept) begin
                    o_cmd.take    = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    o_cmd.ld_out  = (i_command != CMD_READ) && !long_op;
                end
            end
            S_READ: begin
                o_cmd.ld_out       = 1'b1;
                o_cmd.out_from_ram = 1'b1;
            end
            S_SCROLL: begin
                o_cmd.sweep   = SW_MOVE;
                o_cmd.cnt_inc = !i_status.move_end;
            end
            S_BLANK, S_FILL: begin
                o_cmd.sweep   = SW_BLANK;
                o_cmd.cnt_inc = 1'b1;
                o_cmd.ld_out  = i_status.cnt_end;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // a read beat always goes through the ram wait state
    a_read_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_READ) |=> (r_state == S_READ))
        else $error("read beat did not enter ram wait");

    // no beat is taken while a sweep runs
    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("beat taken during sweep");

    // a finished clearing sweep returns to idle
    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_status.cnt_end) |=> (r_state == S_IDLE))
        else $error("clearing sweep did not end");
endmodule

// ----- rtl/ttcs_datapath.sv -----
// ttcs_datapath: cursor, screen ram, sweep counter and result register
// depends on ttcs_pkg and ttcs_ram; commanded by ttcs_ctrl
module ttcs_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ttcs_pkg::t_cmd               i_cmd,
    input  logic [ttcs_pkg::CMD_W-1:0]   i_command,
    input  logic [ttcs_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [ttcs_pkg::POS_W-1:0]   i_read_address,
    input  logic                         i_out_ready,
    output ttcs_pkg::t_status            o_status,
    output logic                         o_out_valid,
    output logic [ttcs_pkg::POS_W-1:0]   o_cursor_position,
    output logic [ttcs_pkg::CHAR_W-1:0]  o_cell_data
);
    import ttcs_pkg::*;

    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    t_addr            r_cnt;
    logic             r_rd_ok;
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_pos;
    t_char            r_out_data;

    t_op   op;
    logic  put;
    logic  rd_ok;
    logic  we;
    t_addr waddr;
    t_char wdata;
    t_addr raddr;
    t_char rdata;
    t_addr cur_addr;
    logic  row_last;
    logic  col_last;

    assign op       = decode_op(i_char_code);
    assign put      = i_cmd.take && (i_command == CMD_PUT);
    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign col_last = (r_col == COL_W'(COLUMNS - 1));
    assign cur_addr = cell_index(r_row, r_col);
    assign rd_ok    = (32'(i_read_address) < 32'(CELLS));

    // status to the controller
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.last_row = row_last;
    assign o_status.at_end   = row_last && col_last;
    assign o_status.move_end = (r_cnt == t_addr'(CELLS - COLUMNS));
    assign o_status.cnt_end  = (r_cnt == t_addr'(CELLS - 1));

    // cursor update for a put beat
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (put) begin
            case (op)
                OP_LF: begin
                    if (!row_last) n_row = r_row + 1'b1;
                end
                OP_CR: n_col = '0;
                OP_FF: begin
                    n_row = '0;
                    n_col = '0;
                end
                OP_LEFT: begin
                    if (r_col != '0) begin
                        n_col = r_col - 1'b1;
                    end else if (r_row != '0) begin
                        n_row = r_row - 1'b1;
                        n_col = COL_W'(COLUMNS - 1);
                    end
                end
                OP_PRINT: begin
                    if (!col_last) begin
                        n_col = r_col + 1'b1;
                    end else begin
                        n_col = '0;
                        if (!row_last) n_row = r_row + 1'b1;
                    end
                end
                default: begin
                    n_row = r_row;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // ram port selection
    always_comb begin
        we    = 1'b0;
        waddr = cur_addr;
        wdata = BLANK;
        raddr = t_addr'(i_read_address);
        case (i_cmd.sweep)
            SW_MOVE: begin
                // read one row ahead, write back what came out last cycle
                raddr = r_cnt + t_addr'(COLUMNS);
                we    = (r_cnt != '0);
                waddr = r_cnt - 1'b1;
                wdata = rdata;
            end
            SW_BLANK: begin
                we    = 1'b1;
                waddr = r_cnt;
                wdata = BLANK;
            end
            SW_ZERO: begin
                we    = 1'b1;
                waddr = r_cnt;
                wdata = '0;
            end
            default: begin
                if (put && (op == OP_ERASE || op == OP_PRINT)) begin
                    we    = 1'b1;
                    wdata = (op == OP_PRINT) ? i_char_code : BLANK;
                end
            end
        endcase
    end

    ttcs_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // read address range flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rd_ok <= rd_ok;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_pos  <= POS_W'(cell_index(n_row, n_col));
            r_out_data <= (i_cmd.out_from_ram && r_rd_ok) ? rdata : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_pos;
    assign o_cell_data       = r_out_data;

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // the row move never writes the cell it reads
    a_move_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep == SW_MOVE && we) |-> (waddr != raddr))
        else $error("scroll read and write collide");

    // cursor stays still during a sweep
    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep != SW_NONE) |=> ($stable(r_row) && $stable(r_col)))
        else $error("cursor moved during sweep");
endmodule

// ----- rtl/text_terminal_cursor_scroll_core.sv -----
// text_terminal_cursor_scroll_core: top level of the 64x16 text terminal core
// depends on ttcs_pkg, ttcs_if, ttcs_ctrl and ttcs_datapath
//
// usage
//   i_in  carries beats of command, char_code and read_address; o_out returns
//   one beat per input beat with the cursor after the item and, for a read,
//   the screen cell (zero for every other command or an address off screen).
//   one item is worked at a time; the screen lives in one ram with one
//   write and one registered read port, which sets the sweeps below.
//   steps from accept to result valid:
//     no action, cursor moves, erase, print without wrap (short items): result registered
//     read: registered ram read, then the result register
//     line feed on the last row or print past the last cell: rows move up
//       one row, then the last row is blanked
//     form feed: every cell is blanked
//   throughput: one item per cycle for short items while o_out takes each result.
//   reset: cursor goes home and a clearing sweep writes zero to every cell,
//     with i_in.ready low throughout.
//   stall: a waiting result sits in the output register; a new beat is taken
//     in the cycle that result is taken or after.
module text_terminal_cursor_scroll_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttcs_in_if.sink     i_in,
    ttcs_out_if.source  o_out
);
    import ttcs_pkg::*;

    t_cmd    cmd;
    t_status status;

    ttcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .i_char_code (i_in.char_code),
        .i_status    (status),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd)
    );

    ttcs_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_command         (i_in.command),
        .i_char_code       (i_in.char_code),
        .i_read_address    (i_in.read_address),
        .i_out_ready       (o_out.ready),
        .o_status          (status),
        .o_out_valid       (o_out.valid),
        .o_cursor_position (o_out.cursor_position),
        .o_cell_data       (o_out.cell_data)
    );
endmodule
